// ===== rtl/sat_pkg.sv =====
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types and constants for the sorted alarm timer table.
// ----------------------------------------------------------------------------
`default_nettype none

package sat_pkg;

   // default sizes
   localparam int CAPACITY_DEF   = 64;
   localparam int ID_BITS_DEF    = 22;
   localparam int COUNT_BITS_DEF = 16;

   // fixed field widths on the ports
   localparam int OP_W     = 2;
   localparam int PID_W    = 22;
   localparam int ALARM_W  = 17;
   localparam int STATUS_W = 3;
   localparam int HELD_W   = 7;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_ERASE  = 2'd1,
      OP_SET    = 2'd2,
      OP_TICK   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_FULL      = 3'd2,
      ST_DUPLICATE = 3'd3,
      ST_EXPIRED   = 3'd4,
      ST_NO_EXPIRY = 3'd5
   } status_type;

   // datapath micro-operations
   typedef enum logic [4:0] {
      CMD_IDLE,
      CMD_LOAD,
      CMD_READ_IDX,
      CMD_SRCH_NEXT,
      CMD_SRCH_DONE,
      CMD_EMIT,
      CMD_INS_START,
      CMD_INS_RD,
      CMD_INS_WR,
      CMD_INS_PUT,
      CMD_ERS_START,
      CMD_ERS_RD,
      CMD_ERS_WR,
      CMD_ERS_FIN,
      CMD_SET_PUT,
      CMD_T1_WR,
      CMD_T2_START,
      CMD_T2_KEEP,
      CMD_EXPIRE,
      CMD_T2_END
   } dp_cmd_type;

   typedef enum logic [3:0] {
      FSM_IDLE,
      FSM_START,
      FSM_SRCH_RD,
      FSM_SRCH_CMP,
      FSM_DISPATCH,
      FSM_INS_RD,
      FSM_INS_WR,
      FSM_ERS_RD,
      FSM_ERS_WR,
      FSM_T1_RD,
      FSM_T1_WR,
      FSM_T2_RD,
      FSM_T2_CHK
   } fsm_type;

   typedef struct packed {
      dp_cmd_type cmd;
      status_type status;   // status for CMD_EMIT
   } dp_ctrl_type;

   typedef struct packed {
      op_type op;
      logic   idx_at_count;
      logic   idx_at_pos;
      logic   erase_end;
      logic   id_lt;
      logic   found;
      logic   full;
      logic   expired_now;
      logic   nexp_zero;
      logic   rsp_free;
   } dp_stat_type;

endpackage

`default_nettype wire

// ===== rtl/sat_ctrl.sv =====
// ----------------------------------------------------------------------------
// sat_ctrl
// Sequencer: walks search, shift, and tick passes by commanding the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module sat_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire sat_pkg::dp_stat_type stat,
   output sat_pkg::dp_ctrl_type      ctrl
);

   sat_pkg::fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sat_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sat_pkg::FSM_IDLE: begin
            if (req_tvalid) state_in = sat_pkg::FSM_START;
         end
         sat_pkg::FSM_START: begin
            state_in = (stat.op == sat_pkg::OP_TICK) ? sat_pkg::FSM_T1_RD
                                                     : sat_pkg::FSM_SRCH_RD;
         end
         sat_pkg::FSM_SRCH_RD: begin
            state_in = stat.idx_at_count ? sat_pkg::FSM_DISPATCH : sat_pkg::FSM_SRCH_CMP;
         end
         sat_pkg::FSM_SRCH_CMP: begin
            state_in = stat.id_lt ? sat_pkg::FSM_SRCH_RD : sat_pkg::FSM_DISPATCH;
         end
         sat_pkg::FSM_DISPATCH: begin
            case (stat.op)
               sat_pkg::OP_INSERT: begin
                  if (stat.found || stat.full) begin
                     if (stat.rsp_free) state_in = sat_pkg::FSM_IDLE;
                  end else begin
                     state_in = sat_pkg::FSM_INS_RD;
                  end
               end
               sat_pkg::OP_ERASE: begin
                  if (!stat.found) begin
                     if (stat.rsp_free) state_in = sat_pkg::FSM_IDLE;
                  end else begin
                     state_in = sat_pkg::FSM_ERS_RD;
                  end
               end
               default: begin
                  if (stat.rsp_free) state_in = sat_pkg::FSM_IDLE;
               end
            endcase
         end
         sat_pkg::FSM_INS_RD: begin
            if (stat.idx_at_pos) begin
               if (stat.rsp_free) state_in = sat_pkg::FSM_IDLE;
            end else begin
               state_in = sat_pkg::FSM_INS_WR;
            end
         end
         sat_pkg::FSM_INS_WR: state_in = sat_pkg::FSM_INS_RD;
         sat_pkg::FSM_ERS_RD: begin
            if (stat.erase_end) begin
               if (stat.rsp_free) state_in = sat_pkg::FSM_IDLE;
            end else begin
               state_in = sat_pkg::FSM_ERS_WR;
            end
         end
         sat_pkg::FSM_ERS_WR: state_in = sat_pkg::FSM_ERS_RD;
         sat_pkg::FSM_T1_RD: begin
            state_in = stat.idx_at_count ? sat_pkg::FSM_T2_RD : sat_pkg::FSM_T1_WR;
         end
         sat_pkg::FSM_T1_WR: state_in = sat_pkg::FSM_T1_RD;
         sat_pkg::FSM_T2_RD: begin
            if (stat.idx_at_count) begin
               if (!stat.nexp_zero || stat.rsp_free) state_in = sat_pkg::FSM_IDLE;
            end else begin
               state_in = sat_pkg::FSM_T2_CHK;
            end
         end
         sat_pkg::FSM_T2_CHK: begin
            if (!stat.expired_now || stat.rsp_free) state_in = sat_pkg::FSM_T2_RD;
         end
         default: state_in = sat_pkg::FSM_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready  = 1'b0;
      ctrl.cmd    = sat_pkg::CMD_IDLE;
      ctrl.status = sat_pkg::ST_OK;
      case (state_ff)
         sat_pkg::FSM_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) ctrl.cmd = sat_pkg::CMD_LOAD;
         end
         sat_pkg::FSM_START: ctrl.cmd = sat_pkg::CMD_IDLE;
         sat_pkg::FSM_SRCH_RD: begin
            ctrl.cmd = stat.idx_at_count ? sat_pkg::CMD_SRCH_DONE : sat_pkg::CMD_READ_IDX;
         end
         sat_pkg::FSM_SRCH_CMP: begin
            ctrl.cmd = stat.id_lt ? sat_pkg::CMD_SRCH_NEXT : sat_pkg::CMD_SRCH_DONE;
         end
         sat_pkg::FSM_DISPATCH: begin
            case (stat.op)
               sat_pkg::OP_INSERT: begin
                  if (stat.found) begin
                     ctrl.status = sat_pkg::ST_DUPLICATE;
                     if (stat.rsp_free) ctrl.cmd = sat_pkg::CMD_EMIT;
                  end else if (stat.full) begin
                     ctrl.status = sat_pkg::ST_FULL;
                     if (stat.rsp_free) ctrl.cmd = sat_pkg::CMD_EMIT;
                  end else begin
                     ctrl.cmd = sat_pkg::CMD_INS_START;
                  end
               end
               sat_pkg::OP_ERASE: begin
                  if (!stat.found) begin
                     ctrl.status = sat_pkg::ST_NOT_FOUND;
                     if (stat.rsp_free) ctrl.cmd = sat_pkg::CMD_EMIT;
                  end else begin
                     ctrl.cmd = sat_pkg::CMD_ERS_START;
                  end
               end
               default: begin
                  if (!stat.found) begin
                     ctrl.status = sat_pkg::ST_NOT_FOUND;
                     if (stat.rsp_free) ctrl.cmd = sat_pkg::CMD_EMIT;
                  end else if (stat.rsp_free) begin
                     ctrl.cmd = sat_pkg::CMD_SET_PUT;
                  end
               end
            endcase
         end
         sat_pkg::FSM_INS_RD: begin
            if (stat.idx_at_pos) begin
               if (stat.rsp_free) ctrl.cmd = sat_pkg::CMD_INS_PUT;
            end else begin
               ctrl.cmd = sat_pkg::CMD_INS_RD;
            end
         end
         sat_pkg::FSM_INS_WR: ctrl.cmd = sat_pkg::CMD_INS_WR;
         sat_pkg::FSM_ERS_RD: begin
            if (stat.erase_end) begin
               if (stat.rsp_free) ctrl.cmd = sat_pkg::CMD_ERS_FIN;
            end else begin
               ctrl.cmd = sat_pkg::CMD_ERS_RD;
            end
         end
         sat_pkg::FSM_ERS_WR: ctrl.cmd = sat_pkg::CMD_ERS_WR;
         sat_pkg::FSM_T1_RD: begin
            ctrl.cmd = stat.idx_at_count ? sat_pkg::CMD_T2_START : sat_pkg::CMD_READ_IDX;
         end
         sat_pkg::FSM_T1_WR: ctrl.cmd = sat_pkg::CMD_T1_WR;
         sat_pkg::FSM_T2_RD: begin
            if (stat.idx_at_count) begin
               if (!stat.nexp_zero || stat.rsp_free) ctrl.cmd = sat_pkg::CMD_T2_END;
            end else begin
               ctrl.cmd = sat_pkg::CMD_READ_IDX;
            end
         end
         sat_pkg::FSM_T2_CHK: begin
            if (!stat.expired_now) begin
               ctrl.cmd = sat_pkg::CMD_T2_KEEP;
            end else if (stat.rsp_free) begin
               ctrl.cmd = sat_pkg::CMD_EXPIRE;
            end
         end
         default: ctrl.cmd = sat_pkg::CMD_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/sat_dp.sv =====
// ----------------------------------------------------------------------------
// sat_dp
// Datapath: entry memory, scan index and counters, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sat_dp #(
   parameter int CAPACITY   = sat_pkg::CAPACITY_DEF,
   parameter int ID_BITS    = sat_pkg::ID_BITS_DEF,
   parameter int COUNT_BITS = sat_pkg::COUNT_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [sat_pkg::OP_W-1:0]      req_op,
   input  wire logic [sat_pkg::PID_W-1:0]     req_pid,
   input  wire logic [sat_pkg::ALARM_W-1:0]   req_alarm,
   input  wire sat_pkg::dp_ctrl_type          ctrl,
   output sat_pkg::dp_stat_type               stat,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [sat_pkg::STATUS_W-1:0]       rsp_status,
   output logic [sat_pkg::PID_W-1:0]          rsp_pid,
   output logic [sat_pkg::HELD_W-1:0]         rsp_held,
   output logic                               rsp_last
);

   localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW      = $clog2(CAPACITY + 1);
   localparam int ENTRY_W = ID_BITS + 1 + COUNT_BITS;   // {id, disarmed, count}
   localparam logic [31:0] MAX_CNT = 32'((64'd1 << COUNT_BITS) - 64'd1);

   // entry memory
   logic [ENTRY_W-1:0] mem [CAPACITY];
   logic [ENTRY_W-1:0] rdata_ff;
   logic               rd_en, wr_en;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rdata_ff <= mem[rd_addr];
   end

   // item registers
   sat_pkg::op_type       op_ff, op_in;
   logic [ID_BITS-1:0]    pid_ff, pid_in;
   logic [sat_pkg::ALARM_W-1:0] alarm_ff, alarm_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         pos_ff, pos_in;
   logic                  found_ff, found_in;
   logic [CW-1:0]         nexp_ff, nexp_in;
   logic [CW-1:0]         keep_ff, keep_in;
   logic [CW-1:0]         emitted_ff, emitted_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sat_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [sat_pkg::PID_W-1:0]     rsp_pid_ff, rsp_pid_in;
   logic [sat_pkg::HELD_W-1:0]    rsp_held_ff, rsp_held_in;
   logic                          rsp_last_ff, rsp_last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      pid_ff        <= pid_in;
      alarm_ff      <= alarm_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      found_ff      <= found_in;
      nexp_ff       <= nexp_in;
      keep_ff       <= keep_in;
      emitted_ff    <= emitted_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pid_ff    <= rsp_pid_in;
      rsp_held_ff   <= rsp_held_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // fields of the last read entry
   logic [ID_BITS-1:0]    rd_id;
   logic                  rd_disarm;
   logic [COUNT_BITS-1:0] rd_cnt;
   logic [COUNT_BITS-1:0] dec_cnt;
   logic                  dec_zero;
   logic [COUNT_BITS-1:0] set_cnt;
   logic                  rsp_free;

   assign rd_id     = rdata_ff[ENTRY_W-1 -: ID_BITS];
   assign rd_disarm = rdata_ff[COUNT_BITS];
   assign rd_cnt    = rdata_ff[COUNT_BITS-1:0];
   assign dec_cnt   = (!rd_disarm && rd_cnt != '0) ? rd_cnt - 1'b1 : rd_cnt;
   assign dec_zero  = !rd_disarm && dec_cnt == '0;
   // saturate the loaded countdown at the top of the count range
   assign set_cnt   = ({16'd0, alarm_ff[15:0]} > MAX_CNT) ? COUNT_BITS'(MAX_CNT)
                                                          : COUNT_BITS'(alarm_ff[15:0]);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      stat.op           = op_ff;
      stat.idx_at_count = idx_ff == count_ff;
      stat.idx_at_pos   = idx_ff == pos_ff;
      stat.erase_end    = ({1'b0, idx_ff} + 1'b1) >= {1'b0, count_ff};
      stat.id_lt        = rd_id < pid_ff;
      stat.found        = found_ff;
      stat.full         = count_ff == CW'(CAPACITY);
      stat.expired_now  = !rd_disarm && rd_cnt == '0;
      stat.nexp_zero    = nexp_ff == '0;
      stat.rsp_free     = rsp_free;
   end

   always_comb begin
      op_in         = op_ff;
      pid_in        = pid_ff;
      alarm_in      = alarm_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      found_in      = found_ff;
      nexp_in       = nexp_ff;
      keep_in       = keep_ff;
      emitted_in    = emitted_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = idx_ff[AW-1:0];
      wr_data       = rdata_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_pid_in    = rsp_pid_ff;
      rsp_held_in   = rsp_held_ff;
      rsp_last_in   = rsp_last_ff;

      case (ctrl.cmd)
         sat_pkg::CMD_LOAD: begin
            op_in    = sat_pkg::op_type'(req_op);
            pid_in   = ID_BITS'(req_pid);
            alarm_in = req_alarm;
            idx_in   = '0;
            nexp_in  = '0;
         end
         sat_pkg::CMD_READ_IDX: rd_en = 1'b1;
         sat_pkg::CMD_SRCH_NEXT: idx_in = idx_ff + 1'b1;
         sat_pkg::CMD_SRCH_DONE: begin
            pos_in   = idx_ff;
            found_in = (idx_ff != count_ff) && (rd_id == pid_ff);
         end
         sat_pkg::CMD_EMIT: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ctrl.status;
            rsp_pid_in    = sat_pkg::PID_W'(pid_ff);
            rsp_held_in   = sat_pkg::HELD_W'(count_ff);
            rsp_last_in   = 1'b1;
         end
         sat_pkg::CMD_INS_START: idx_in = count_ff;
         sat_pkg::CMD_INS_RD: begin
            rd_en   = 1'b1;
            rd_addr = AW'(idx_ff - 1'b1);
         end
         sat_pkg::CMD_INS_WR: begin
            wr_en  = 1'b1;
            idx_in = idx_ff - 1'b1;
         end
         sat_pkg::CMD_INS_PUT: begin
            wr_en         = 1'b1;
            wr_addr       = pos_ff[AW-1:0];
            wr_data       = {pid_ff, 1'b1, {COUNT_BITS{1'b1}}};
            count_in      = count_ff + 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_status_in = sat_pkg::ST_OK;
            rsp_pid_in    = sat_pkg::PID_W'(pid_ff);
            rsp_held_in   = sat_pkg::HELD_W'(count_ff + 1'b1);
            rsp_last_in   = 1'b1;
         end
         sat_pkg::CMD_ERS_START: idx_in = pos_ff;
         sat_pkg::CMD_ERS_RD: begin
            rd_en   = 1'b1;
            rd_addr = AW'(idx_ff + 1'b1);
         end
         sat_pkg::CMD_ERS_WR: begin
            wr_en  = 1'b1;
            idx_in = idx_ff + 1'b1;
         end
         sat_pkg::CMD_ERS_FIN: begin
            count_in      = count_ff - 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_status_in = sat_pkg::ST_OK;
            rsp_pid_in    = sat_pkg::PID_W'(pid_ff);
            rsp_held_in   = sat_pkg::HELD_W'(count_ff - 1'b1);
            rsp_last_in   = 1'b1;
         end
         sat_pkg::CMD_SET_PUT: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff[AW-1:0];
            if (alarm_ff[sat_pkg::ALARM_W-1]) begin
               wr_data = {rd_id, 1'b1, {COUNT_BITS{1'b1}}};
            end else begin
               wr_data = {rd_id, 1'b0, set_cnt};
            end
            rsp_valid_in  = 1'b1;
            rsp_status_in = sat_pkg::ST_OK;
            rsp_pid_in    = sat_pkg::PID_W'(pid_ff);
            rsp_held_in   = sat_pkg::HELD_W'(count_ff);
            rsp_last_in   = 1'b1;
         end
         sat_pkg::CMD_T1_WR: begin
            wr_en   = 1'b1;
            wr_data = {rd_id, rd_disarm, dec_cnt};
            idx_in  = idx_ff + 1'b1;
            if (dec_zero) nexp_in = nexp_ff + 1'b1;
         end
         sat_pkg::CMD_T2_START: begin
            idx_in     = '0;
            keep_in    = '0;
            emitted_in = '0;
         end
         sat_pkg::CMD_T2_KEEP: begin
            wr_en   = 1'b1;
            wr_addr = keep_ff[AW-1:0];
            keep_in = keep_ff + 1'b1;
            idx_in  = idx_ff + 1'b1;
         end
         sat_pkg::CMD_EXPIRE: begin
            emitted_in    = emitted_ff + 1'b1;
            idx_in        = idx_ff + 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_status_in = sat_pkg::ST_EXPIRED;
            rsp_pid_in    = sat_pkg::PID_W'(rd_id);
            rsp_held_in   = sat_pkg::HELD_W'(count_ff - emitted_ff - 1'b1);
            rsp_last_in   = (emitted_ff + 1'b1) == nexp_ff;
         end
         sat_pkg::CMD_T2_END: begin
            count_in = keep_ff;
            if (nexp_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = sat_pkg::ST_NO_EXPIRY;
               rsp_pid_in    = '0;
               rsp_held_in   = sat_pkg::HELD_W'(keep_ff);
               rsp_last_in   = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_pid    = rsp_pid_ff;
   assign rsp_held   = rsp_held_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/sorted_alarm_timer_table.sv =====
// ----------------------------------------------------------------------------
// sorted_alarm_timer_table
// Sorted table of process ids with per-id alarm countdowns.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one beat per command (insert, erase, set alarm, tick).
//    Commands are taken one at a time; req_tready is high only while idle.
//  - rsp channel: one beat per command, except a tick with expiries, which
//    gives one beat per expired id in ascending order, tlast on the final.
//  - Sequencing: a lookup scans the table one entry at a time, each step
//    waiting on a registered memory read. Insert/erase then shift the tail
//    one moved entry at a time. A tick makes two passes over the entries
//    held (decrement, then compact and report).
//  - The result register lets the block finish a command while its last
//    beat waits; when rsp_tready is low the sequence stalls at the next beat.
//  - Reset clears the entry count and the result valid; memory contents are
//    don't-care since only entries below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_alarm_timer_table #(
   parameter int CAPACITY   = sat_pkg::CAPACITY_DEF,
   parameter int ID_BITS    = sat_pkg::ID_BITS_DEF,
   parameter int COUNT_BITS = sat_pkg::COUNT_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // op[1:0], pid[23:2], alarm_seconds[40:24], zero fill [47:41]
   input  wire logic [sat_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // status[2:0], pid_out[24:3], entries_held[31:25]
   output logic [sat_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                   rsp_tlast
);

   sat_pkg::dp_ctrl_type ctrl;
   sat_pkg::dp_stat_type stat;

   logic [sat_pkg::STATUS_W-1:0] rsp_status;
   logic [sat_pkg::PID_W-1:0]    rsp_pid;
   logic [sat_pkg::HELD_W-1:0]   rsp_held;

   sat_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .ctrl       (ctrl)
   );

   sat_dp #(
      .CAPACITY   (CAPACITY),
      .ID_BITS    (ID_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_op     (req_tdata[1:0]),
      .req_pid    (req_tdata[23:2]),
      .req_alarm  (req_tdata[40:24]),
      .ctrl       (ctrl),
      .stat       (stat),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_pid    (rsp_pid),
      .rsp_held   (rsp_held),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {rsp_held, rsp_pid, rsp_status};

endmodule

`default_nettype wire
